FILE: rtl/mma_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mma_pkg: shared types for the matrix multiply-accumulate unit
// Request and result structs, action codes and sequencer states.
// ----------------------------------------------------------------------------
package mma_pkg;

  // request action codes (5 to 7 unused)
  typedef enum logic [2:0] {
    ACT_WR_A = 3'd0,
    ACT_WR_B = 3'd1,
    ACT_WR_C = 3'd2,
    ACT_RUN  = 3'd3,
    ACT_RD_C = 3'd4
  } action_e;

  // one request
  typedef struct packed {
    logic [2:0]         action;
    logic [3:0]         row;
    logic [3:0]         col;
    logic signed [31:0] value;
  } mma_req_t;

  // one result
  typedef struct packed {
    logic signed [31:0] read_value;
    logic               done_res;
  } mma_res_t;

  // product sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_CRD,
    S_MAC,
    S_DRAIN
  } state_e;

  localparam logic signed [63:0] SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] SAT_MIN = -64'sh0000_0000_8000_0000;

endpackage

FILE: rtl/matrix_multiply_accumulate_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_multiply_accumulate_unit: C = C + A*B on local element stores
// Column-major A, B, C stores; one shared 32x32 multiplier and 64-bit
// accumulator walk every C element under a small sequencer.
// ----------------------------------------------------------------------------
//  channel   ports                          handshake
//  request   start, busy, req_i             taken when start && !busy
//  result    res_valid_o, res_o             one-cycle strobe, no backpressure
//
//  Writes of A, B and C and reads of C get their result in the cycle after
//  the request, and a new request may be taken meanwhile.
//  A run keeps busy high while the single multiplier and the one read port
//  per store walk every C element; done strobes as busy falls. Reset clears
//  control only; store contents are undefined until written. The receiver
//  cannot stall results.
// ----------------------------------------------------------------------------
module matrix_multiply_accumulate_unit #(
  parameter int ROWS  = 16,
  parameter int COLS  = 16,
  parameter int INNER = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  mma_pkg::mma_req_t req_i,
  output logic              res_valid_o,
  output mma_pkg::mma_res_t res_o
);
  import mma_pkg::*;

  localparam int ADEPTH = ROWS * INNER;
  localparam int BDEPTH = INNER * COLS;
  localparam int CDEPTH = ROWS * COLS;
  localparam int AAW = (ADEPTH > 1) ? $clog2(ADEPTH) : 1;
  localparam int BAW = (BDEPTH > 1) ? $clog2(BDEPTH) : 1;
  localparam int CAW = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;
  localparam int IW  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int JW  = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int KW  = (INNER > 1) ? $clog2(INNER) : 1;

  // element stores
  logic signed [31:0] a_mem [ADEPTH];
  logic signed [31:0] b_mem [BDEPTH];
  logic signed [31:0] c_mem [CDEPTH];

  state_e state_q, state_d;
  logic [IW-1:0] i_q, i_d;
  logic [JW-1:0] j_q, j_d;
  logic [KW-1:0] k_q, k_d;
  logic          v1_q, v2_q, issue;
  logic          acc_init;
  logic signed [31:0] a_rdata_q, b_rdata_q, c_rdata_q;
  logic signed [63:0] prod_q, acc_q, acc_d;
  logic          res_valid_q, res_valid_d;
  logic          res_done_q, res_done_d;
  logic          res_rd_q, res_rd_d;
  logic          accept;
  logic          a_we, b_we, c_we;
  logic [AAW-1:0] a_raddr, a_waddr;
  logic [BAW-1:0] b_raddr, b_waddr;
  logic [CAW-1:0] c_raddr, c_waddr, c_host_addr, c_seq_addr;
  logic signed [31:0] c_wdata, sat_val;
  logic          in_a, in_b, in_c;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;

  // request decode and range checks
  assign in_a = (int'(req_i.row) < ROWS)  && (int'(req_i.col) < INNER);
  assign in_b = (int'(req_i.row) < INNER) && (int'(req_i.col) < COLS);
  assign in_c = (int'(req_i.row) < ROWS)  && (int'(req_i.col) < COLS);

  assign a_waddr     = AAW'(int'(req_i.col) * ROWS + int'(req_i.row));
  assign b_waddr     = BAW'(int'(req_i.col) * INNER + int'(req_i.row));
  assign c_host_addr = CAW'(int'(req_i.col) * ROWS + int'(req_i.row));

  // sequencer addresses: A(i,k), B(k,j), C(i,j)
  assign a_raddr    = AAW'(int'(k_q) * ROWS + int'(i_q));
  assign b_raddr    = BAW'(int'(j_q) * INNER + int'(k_q));
  assign c_seq_addr = CAW'(int'(j_q) * ROWS + int'(i_q));

  // saturate the exact sum to 32 bits
  always_comb begin
    if (acc_q > SAT_MAX) begin
      sat_val = 32'sh7FFF_FFFF;
    end else if (acc_q < SAT_MIN) begin
      sat_val = -32'sh8000_0000;
    end else begin
      sat_val = acc_q[31:0];
    end
  end

  // next state and control
  always_comb begin
    state_d     = state_q;
    i_d         = i_q;
    j_d         = j_q;
    k_d         = k_q;
    issue       = 1'b0;
    acc_init    = 1'b0;
    c_we        = 1'b0;
    c_waddr     = c_host_addr;
    c_wdata     = req_i.value;
    c_raddr     = c_host_addr;
    a_we        = 1'b0;
    b_we        = 1'b0;
    res_valid_d = 1'b0;
    res_done_d  = 1'b0;
    res_rd_d    = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_valid_d = 1'b1;
          case (req_i.action)
            ACT_WR_A: a_we = in_a;
            ACT_WR_B: b_we = in_b;
            ACT_WR_C: c_we = in_c;
            ACT_RUN: begin
              res_valid_d = 1'b0;
              i_d         = '0;
              j_d         = '0;
              state_d     = S_CRD;
            end
            ACT_RD_C: begin
              res_done_d = 1'b1;
              res_rd_d   = in_c;
            end
            default: ;
          endcase
        end
      end
      S_CRD: begin
        // fetch the old C element
        c_raddr = c_seq_addr;
        k_d     = '0;
        state_d = S_MAC;
      end
      S_MAC: begin
        // issue one A/B pair per cycle
        c_raddr = c_seq_addr;
        issue   = 1'b1;
        if (k_q == KW'(0)) begin
          acc_init = 1'b1;
        end
        if (k_q == KW'(INNER - 1)) begin
          state_d = S_DRAIN;
        end else begin
          k_d = k_q + KW'(1);
        end
      end
      S_DRAIN: begin
        c_raddr = c_seq_addr;
        if (!v1_q && !v2_q) begin
          // write back and step to the next element
          c_we    = 1'b1;
          c_waddr = c_seq_addr;
          c_wdata = sat_val;
          state_d = S_CRD;
          if (i_q == IW'(ROWS - 1)) begin
            i_d = '0;
            if (j_q == JW'(COLS - 1)) begin
              state_d     = S_IDLE;
              res_valid_d = 1'b1;
              res_done_d  = 1'b1;
            end else begin
              j_d = j_q + JW'(1);
            end
          end else begin
            i_d = i_q + IW'(1);
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // accumulator: load old C, then add truncated products
  always_comb begin
    acc_d = acc_q;
    if (acc_init) begin
      acc_d = 64'(c_rdata_q);
    end
    if (v2_q) begin
      acc_d = acc_d + (prod_q >>> 16);
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      res_valid_q <= 1'b0;
      res_done_q  <= 1'b0;
      res_rd_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      i_q         <= i_d;
      j_q         <= j_d;
      k_q         <= k_d;
      v1_q        <= issue;
      v2_q        <= v1_q;
      res_valid_q <= res_valid_d;
      res_done_q  <= res_done_d;
      res_rd_q    <= res_rd_d;
    end
  end

  // multiplier and accumulator datapath
  always_ff @(posedge clk_i) begin
    prod_q <= a_rdata_q * b_rdata_q;
    acc_q  <= acc_d;
  end

  // stores: one write and one registered read each
  always_ff @(posedge clk_i) begin
    if (a_we) begin
      a_mem[a_waddr] <= req_i.value;
    end
    a_rdata_q <= a_mem[a_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (b_we) begin
      b_mem[b_waddr] <= req_i.value;
    end
    b_rdata_q <= b_mem[b_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (c_we) begin
      c_mem[c_waddr] <= c_wdata;
    end
    c_rdata_q <= c_mem[c_raddr];
  end

  // result
  assign res_valid_o      = res_valid_q;
  assign res_o.done_res   = res_done_q;
  assign res_o.read_value = res_rd_q ? c_rdata_q : 32'sd0;

endmodule
